FILE: rtl/csdq_pkg.sv
// ----------------------------------------------------------------------------
// csdq_pkg
// Shared types and constants of the code-block sample dequantizer.
// ----------------------------------------------------------------------------
package csdq_pkg;

	// Configuration register map
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 31;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAG_PLANES = 2'd0,
		REG_ROI_SHIFT  = 2'd1,
		REG_REV_MODE   = 2'd2,
		REG_STEP_SCALE = 2'd3
	} cfg_reg_t;

	// Register reset values
	localparam logic [4:0]  MAG_PLANES_RST = 5'd16;
	localparam logic [4:0]  ROI_SHIFT_RST  = 5'd0;
	localparam logic        REV_MODE_RST   = 1'b1;
	localparam logic [30:0] STEP_SCALE_RST = 31'd0;

	// Stream payload widths
	localparam int SAMPLE_W = 32;
	localparam int STATE_W  = 8;
	localparam int IN_W     = SAMPLE_W + STATE_W;
	localparam int COEF_W   = 32;
	localparam int MAG_W    = 31;

	// Irreversible path fixed-point widths
	localparam int Q_W    = 16;
	localparam int PROD_W = Q_W + MAG_W;

	// Rounding constants (downshift of 15 after the scale multiply)
	localparam logic [MAG_W:0]    Q_ROUND   = 32'd32768;
	localparam logic [PROD_W-1:0] P_ROUND   = 47'd16384;
	localparam logic [MAG_W-1:0]  SAT_LIMIT = 31'h7FFF_FFFF;

endpackage

FILE: rtl/codeblock_sample_dequantizer.sv
// ----------------------------------------------------------------------------
// codeblock_sample_dequantizer
// Turns a sign-magnitude code-block sample into a signed coefficient: ROI
// down-shift, half-interval reconstruction, then either a floor shift
// (reversible) or a rounded scale multiply with saturation (irreversible).
// ----------------------------------------------------------------------------
//
//  channel   | signals                       | beat payload
//  ----------+-------------------------------+-----------------------------------
//  s_axis    | tvalid, tready, tdata[39:0]   | sample_word, pass_state
//  m_axis    | tvalid, tready, tdata[31:0]   | coefficient
//  cfg       | valid, ready, index, data     | register write, always ready
//
//  Three register stages: ROI/reconstruction, shift or multiply, round and
//  saturate. One sample per cycle while the output is not stalled; the 16x31
//  multiply in the second stage sets the cycle time.
//  Reset clears the stage valid bits and loads the register defaults.
//  A stalled output holds its beat; bubbles collapse, nothing is dropped.
//
module codeblock_sample_dequantizer (
	input  logic                              clk,
	input  logic                              arst_n,
	// Input stream
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [csdq_pkg::IN_W-1:0]         s_axis_tdata,  // [31:0] sample_word, [39:32] pass_state
	// Output stream
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [csdq_pkg::COEF_W-1:0]       m_axis_tdata,  // [31:0] coefficient
	// Configuration writes
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [csdq_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [csdq_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import csdq_pkg::*;

	// Configuration registers
	logic [4:0]       mag_planes_q;
	logic [4:0]       roi_shift_q;
	logic             rev_mode_q;
	logic [MAG_W-1:0] step_scale_q;

	assign cfg_ready = 1'b1;

	// Take register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mag_planes_q <= MAG_PLANES_RST;
			roi_shift_q  <= ROI_SHIFT_RST;
			rev_mode_q   <= REV_MODE_RST;
			step_scale_q <= STEP_SCALE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_MAG_PLANES: mag_planes_q <= cfg_data[4:0];
				REG_ROI_SHIFT:  roi_shift_q  <= cfg_data[4:0];
				REG_REV_MODE:   rev_mode_q   <= cfg_data[0];
				REG_STEP_SCALE: step_scale_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Pipeline flow control
	logic valid_s1, valid_s2, valid_s3;
	logic ready_s1, ready_s2, ready_s3;

	assign ready_s3      = !valid_s3 || m_axis_tready;
	assign ready_s2      = !valid_s2 || ready_s3;
	assign ready_s1      = !valid_s1 || ready_s2;
	assign s_axis_tready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= s_axis_tvalid;
			if (ready_s2) valid_s2 <= valid_s1;
			if (ready_s3) valid_s3 <= valid_s2;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: undo ROI up-shift, place reconstruction bit
	// ------------------------------------------------------------------
	logic [MAG_W-1:0] in_mag;
	logic             in_neg;
	logic [4:0]       in_zero_planes;
	logic [4:0]       lsb_pos;
	logic             roi_fits;
	logic [MAG_W-1:0] roi_mag;
	logic [MAG_W-1:0] mag_r;
	logic [4:0]       coded_planes;
	logic             planes_missing;
	logic [4:0]       recon_pos;
	logic             recon_ok;
	logic             recon_set;
	logic [MAG_W-1:0] recon_bit;

	always_comb begin
		in_mag         = s_axis_tdata[MAG_W-1:0];
		in_neg         = s_axis_tdata[SAMPLE_W-1];
		in_zero_planes = s_axis_tdata[IN_W-1 -: 5];
		lsb_pos        = 5'd31 - mag_planes_q;
		// Magnitude fits below the ROI mask when nothing lies at or above the LSB
		roi_fits       = ((in_mag >> lsb_pos) == '0);
		roi_mag        = in_mag << roi_shift_q;
		mag_r          = ((roi_shift_q != '0) && roi_fits) ? roi_mag : in_mag;
		coded_planes   = (roi_shift_q != '0) ? mag_planes_q : (5'd31 - in_zero_planes);
		planes_missing = (coded_planes < mag_planes_q);
		recon_pos      = planes_missing ? (5'd30 - coded_planes) : (5'd30 - mag_planes_q);
		recon_ok       = planes_missing || (mag_planes_q != 5'd31);
		recon_set      = (mag_r != '0) && (rev_mode_q ? planes_missing : recon_ok);
		recon_bit      = recon_set ? (MAG_W'(1) << recon_pos) : '0;
	end

	logic [MAG_W-1:0] mag_s1;
	logic             neg_s1;

	always_ff @(posedge clk) begin
		if (ready_s1) begin
			mag_s1 <= mag_r | recon_bit;
			neg_s1 <= in_neg;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: floor shift (reversible) or scale multiply (irreversible)
	// ------------------------------------------------------------------
	logic signed [COEF_W-1:0] signed_mag;
	logic signed [COEF_W-1:0] rev_val;
	logic [MAG_W:0]           q_sum;
	logic [Q_W-1:0]           q_val;

	always_comb begin
		signed_mag = neg_s1 ? -$signed({1'b0, mag_s1}) : $signed({1'b0, mag_s1});
		rev_val    = signed_mag >>> lsb_pos;
		q_sum      = {1'b0, mag_s1} + Q_ROUND;
		q_val      = q_sum[MAG_W:16];
	end

	logic [COEF_W-1:0] rev_s2;
	logic [PROD_W-1:0] prod_s2;
	logic              neg_s2;

	always_ff @(posedge clk) begin
		if (ready_s2) begin
			rev_s2  <= rev_val;
			prod_s2 <= PROD_W'(q_val) * PROD_W'(step_scale_q);
			neg_s2  <= neg_s1;
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: round, saturate, apply sign, pick the path
	// ------------------------------------------------------------------
	logic [PROD_W-1:0] p_sum;
	logic [COEF_W-1:0] p_val;
	logic [MAG_W-1:0]  p_sat;
	logic [COEF_W-1:0] irr_val;

	always_comb begin
		p_sum   = prod_s2 + P_ROUND;
		p_val   = p_sum[PROD_W-1 -: COEF_W];
		p_sat   = (p_val > {1'b0, SAT_LIMIT}) ? SAT_LIMIT : p_val[MAG_W-1:0];
		irr_val = neg_s2 ? (COEF_W'(0) - {1'b0, p_sat}) : {1'b0, p_sat};
	end

	logic [COEF_W-1:0] coef_s3;

	always_ff @(posedge clk) begin
		if (ready_s3) begin
			coef_s3 <= rev_mode_q ? rev_s2 : irr_val;
		end
	end

	assign m_axis_tvalid = valid_s3;
	assign m_axis_tdata  = coef_s3;

endmodule

FILE: test/codeblock_sample_dequantizer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// codeblock_sample_dequantizer_tb
// Streams sign-magnitude samples with pass-state bytes through the
// dequantizer under a series of register settings. Each accepted input beat
// is run through a local model of the ROI down-shift, the reconstruction bit
// and the reversible or irreversible path. Each output beat is checked
// against the oldest prediction. The sender works in bursts and the receiver
// stalls on its own schedule. Registers change only while the pipeline is
// drained.
// ----------------------------------------------------------------------------
module codeblock_sample_dequantizer_tb;
	import csdq_pkg::*;

	typedef struct packed {
		logic [7:0]  pass_state;
		logic [31:0] sample_word;
	} sample_beat_t;

	typedef struct {
		sample_beat_t beat;
		logic [31:0]  coefficient;
	} coef_pending_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_W-1:0]       s_axis_tdata = '0;   // [31:0] sample_word, [39:32] pass_state
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [COEF_W-1:0]     m_axis_tdata;        // [31:0] coefficient
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Register shadow used by the predictor
	logic [4:0]  cur_planes    = MAG_PLANES_RST;
	logic [4:0]  cur_roi_shift = ROI_SHIFT_RST;
	logic        cur_reversible = REV_MODE_RST;
	logic [30:0] cur_step_scale = STEP_SCALE_RST;

	sample_beat_t  pending_samples[$];
	coef_pending_t coef_expected[$];
	coef_pending_t coef_head;
	int            mismatch_count = 0;
	logic          beat_taken = 1'b0;
	int            burst_left = 8;
	int            gap_left = 0;
	int            stall_mode = 0;
	int            stall_hold = 0;
	logic [15:0]   stall_pattern = 16'hFFFF;

	codeblock_sample_dequantizer DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #4 clk = ~clk;

	// Predict the coefficient for one sample under the current registers
	function automatic logic [31:0] dequantize_sample(input sample_beat_t beat);
		logic [30:0]         mag;
		logic [31:0]         roi_mask;
		int                  planes;
		int                  coded;
		int                  recon_pos;
		longint signed       signed_mag;
		longint unsigned     q_val;
		longint unsigned     p_val;
		planes = int'(cur_planes);
		mag = beat.sample_word[30:0];
		roi_mask = (planes == 31) ? 32'd0 : (32'hFFFF_FFFF >> (planes + 1));
		// undo the ROI up-shift only when the magnitude sits below the mask
		if (cur_roi_shift != 0 && (({1'b0, mag} & ~roi_mask) == 32'd0))
			mag = mag << cur_roi_shift;
		coded = (cur_roi_shift != 0) ? planes : 31 - int'(beat.pass_state[7:3]);
		recon_pos = 30 - planes + ((planes > coded) ? planes - coded : 0);
		if (cur_reversible) begin
			if (mag != 0 && coded < planes && recon_pos >= 0)
				mag[recon_pos] = 1'b1;
			signed_mag = beat.sample_word[31] ? -longint'(mag) : longint'(mag);
			return 32'(signed_mag >>> (31 - planes));
		end
		if (mag != 0 && recon_pos >= 0)
			mag[recon_pos] = 1'b1;
		q_val = (longint'(mag) + 64'd32768) >> 16;
		p_val = (q_val * longint'(cur_step_scale) + 64'd16384) >> 15;
		if (p_val > 64'h7FFF_FFFF)
			p_val = 64'h7FFF_FFFF;
		return beat.sample_word[31] ? 32'(-p_val) : 32'(p_val);
	endfunction

	// Draw a sample; narrow magnitudes are mixed in so some fit under ROI masks
	function automatic sample_beat_t random_sample();
		sample_beat_t beat;
		logic [30:0]  mag;
		case ($urandom_range(0, 9))
			0: mag = '0;
			1: mag = '1;
			2, 3, 4, 5: mag = 31'($urandom) >> $urandom_range(0, 30);
			default: mag = 31'($urandom);
		endcase
		beat.sample_word = {1'($urandom), mag};
		beat.pass_state = 8'($urandom);
		return beat;
	endfunction

	task automatic report_mismatch(input string what);
		mismatch_count++;
		// keep the log short when the design is badly off
		if (mismatch_count <= 100)
			$display("mismatch @%0t: %s", $time, what);
	endtask

	task automatic write_register(input cfg_reg_t index, input logic [30:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (index)
			REG_MAG_PLANES: cur_planes     = value[4:0];
			REG_ROI_SHIFT:  cur_roi_shift  = value[4:0];
			REG_REV_MODE:   cur_reversible = value[0];
			REG_STEP_SCALE: cur_step_scale = value;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Wait until every sample is out, then let the pipeline settle
	task automatic wait_drained();
		while (pending_samples.size() != 0 || coef_expected.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	// Narrow registers carry random upper bits that must be ignored
	task automatic set_registers(input logic [4:0] planes, input logic [4:0] roi,
			input logic rev, input logic [30:0] scale);
		wait_drained();
		write_register(REG_MAG_PLANES, {26'($urandom), planes});
		write_register(REG_ROI_SHIFT, {26'($urandom), roi});
		write_register(REG_REV_MODE, {30'($urandom), rev});
		write_register(REG_STEP_SCALE, scale);
	endtask

	task automatic queue_sample(input logic [31:0] word, input logic [7:0] state);
		sample_beat_t beat;
		beat.sample_word = word;
		beat.pass_state = state;
		pending_samples.push_back(beat);
	endtask

	// Sender: bursts of beats separated by random gaps; hold a beat until taken
	always @(negedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || beat_taken) begin
			beat_taken = 1'b0;
			if (gap_left != 0) begin
				gap_left--;
				s_axis_tvalid <= 1'b0;
			end else if (pending_samples.size() != 0) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= {pending_samples[0].pass_state, pending_samples[0].sample_word};
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left--;
				end
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: switch between always ready, coin flips, a rotating pattern
	// and heavy back-pressure
	always @(negedge clk) begin
		if (stall_hold != 0) begin
			stall_hold--;
		end else begin
			stall_mode = $urandom_range(0, 3);
			stall_hold = $urandom_range(20, 150);
			stall_pattern = 16'($urandom);
		end
		stall_pattern = {stall_pattern[14:0], stall_pattern[15]};
		case (stall_mode)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= 1'($urandom);
			2: m_axis_tready <= stall_pattern[0];
			default: m_axis_tready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	// Record predictions for accepted inputs and check accepted outputs
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				coef_head.beat = pending_samples.pop_front();
				coef_head.coefficient = dequantize_sample(coef_head.beat);
				coef_expected.push_back(coef_head);
				beat_taken = 1'b1;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (coef_expected.size() == 0) begin
					report_mismatch($sformatf("coefficient %h with no sample pending",
						m_axis_tdata));
				end else begin
					coef_head = coef_expected.pop_front();
					if (m_axis_tdata !== coef_head.coefficient)
						report_mismatch($sformatf(
							"sample %h state %h: coefficient %h, want %h",
							coef_head.beat.sample_word, coef_head.beat.pass_state,
							m_axis_tdata, coef_head.coefficient));
				end
			end
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset settings: zero, negative zero, full magnitudes, plane counts
		queue_sample(32'h0000_0000, 8'h00);
		queue_sample(32'h8000_0000, 8'hFF);
		queue_sample(32'h7FFF_FFFF, 8'h00);
		queue_sample(32'hFFFF_FFFF, 8'hF8);
		queue_sample(32'h0000_8000, 8'h80);
		queue_sample(32'h8001_0000, 8'h87);

		// Irreversible with the largest scale: saturation both ways
		set_registers(5'd16, 5'd0, 1'b0, 31'h7FFF_FFFF);
		queue_sample(32'h7FFF_FFFF, 8'h00);
		queue_sample(32'hFFFF_FFFF, 8'hFF);
		queue_sample(32'h8000_0000, 8'h50);
		queue_sample(32'h0000_0001, 8'h50);

		// All 31 planes: empty ROI mask, no shift down
		set_registers(5'd31, 5'd0, 1'b1, 31'd1);
		queue_sample(32'h7FFF_FFFF, 8'hF8);
		queue_sample(32'h8000_0001, 8'h00);

		// No planes with the widest ROI shift: every bit shifts out
		set_registers(5'd0, 5'd31, 1'b1, 31'd0);
		queue_sample(32'h0000_0001, 8'h00);
		queue_sample(32'hC000_0000, 8'hFF);
		queue_sample(32'h8000_0003, 8'h33);

		// ROI shift overflow and a magnitude above the mask
		set_registers(5'd10, 5'd20, 1'b0, 31'h0001_0000);
		queue_sample(32'h001F_FFFF, 8'h00);
		queue_sample(32'h0020_0000, 8'h00);
		queue_sample(32'h8000_0005, 8'hA8);

		// Irreversible with no reconstruction bit position
		set_registers(5'd31, 5'd0, 1'b0, 31'd12345);
		queue_sample(32'h7FFF_FFFF, 8'h00);
		queue_sample(32'h0000_0000, 8'hFF);

		// Random phases; the first ones pin register extremes
		for (int phase = 0; phase < 14; phase++) begin
			case (phase)
				0: set_registers(5'd16, 5'd0, 1'b1, 31'd0);
				1: set_registers(5'd0, 5'd0, 1'b1, 31'($urandom));
				2: set_registers(5'd31, 5'd0, 1'b1, 31'($urandom));
				3: set_registers(5'd30, 5'd31, 1'b1, 31'($urandom));
				4: set_registers(5'd1, 5'd1, 1'b0, 31'h7FFF_FFFF);
				5: set_registers(5'd31, 5'd31, 1'b0, 31'd0);
				6: set_registers(5'd0, 5'd17, 1'b0, 31'($urandom) >> $urandom_range(0, 30));
				default: set_registers(5'($urandom),
					($urandom_range(0, 1) == 0) ? 5'd0 : 5'($urandom_range(1, 31)),
					1'($urandom), 31'($urandom) >> $urandom_range(0, 30));
			endcase
			for (int n = 0; n < 96; n++)
				pending_samples.push_back(random_sample());
		end

		wait_drained();
		if (mismatch_count == 0 && coef_expected.size() == 0)
			$display("[codeblock_sample_dequantizer] OK");
		else
			$display("[codeblock_sample_dequantizer] ERROR");
		$finish;
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("[codeblock_sample_dequantizer] ERROR");
		$finish;
	end

endmodule
